[hw/rtl/jkie_pkg.sv]
// Shared types, key text and constants of the JSON key integer extractor.
package jkie_pkg;

	localparam int unsigned KEY_LEN         = 15;
	localparam int unsigned MAX_VALUE_CHARS = 3;
	localparam int unsigned SPEED_MAX       = 999;
	localparam int unsigned SPEED_W         = 10;
	localparam int unsigned POS_W           = 4;
	localparam int unsigned CNT_W           = 3;

	localparam logic [7:0] VALUE_END  = 8'h2c; // ','
	localparam logic [7:0] DIGIT_ZERO = 8'h30;
	localparam logic [7:0] DIGIT_NINE = 8'h39;

	// "currentSpeed": including both quotes
	localparam logic [7:0] KEY_TEXT [KEY_LEN] = '{
		8'h22, 8'h63, 8'h75, 8'h72, 8'h72, 8'h65, 8'h6e, 8'h74,
		8'h53, 8'h70, 8'h65, 8'h65, 8'h64, 8'h22, 8'h3a
	};

	typedef enum logic {
		CMD_NEW_RESPONSE = 1'b0,
		CMD_DATA         = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		ST_SEARCHING = 2'd0,
		ST_FOUND_NOW = 2'd1,
		ST_TOO_LONG  = 2'd2,
		ST_ALREADY   = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		PH_SEARCH  = 2'd0,
		PH_COLLECT = 2'd1,
		PH_FOUND   = 2'd2
	} phase_t;

	// One byte presented to the parser core; adv commits its state update.
	typedef struct packed {
		logic       adv;
		cmd_t       cmd;
		logic [7:0] data;
	} step_req_t;

	typedef struct packed {
		status_t              status;
		logic [SPEED_W-1:0]   speed;
	} step_rsp_t;

endpackage

[hw/rtl/json_key_integer_extractor_top.sv]
// Top level of the streaming JSON key integer extractor: input and result registers.
//
//  channel | dir | tdata                     | tuser
//  --------+-----+---------------------------+-------------------------------------
//  s_*     | in  | [7:0] data_byte           | [0] command (0 new response, 1 data)
//  m_*     | out | [9:0] speed, [15:10] zero | [1:0] status
//
// One beat per cycle sustained while m_tready does not stall; a byte taken sits in the
// input register and then moves to the result register (parser core between the two).
// The parser state loop (key matcher, value accumulator) closes through the parser state registers.
// arst_n clears both valid flags and all parser state; a new-response beat does the same
// to parser state in-band. A stalled m_tready holds the result, and the input register
// keeps taking a beat while it is empty or the result register is empty or draining.
module json_key_integer_extractor_top import jkie_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] data_byte
	input  logic        s_tuser,  // [0] command
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // [9:0] speed, [15:10] zero
	output logic [1:0]  m_tuser   // [1:0] status
);

	logic               valid_s1;
	cmd_t               cmd_s1;
	logic [7:0]         data_s1;
	logic               valid_s2;
	status_t            status_s2;
	logic [SPEED_W-1:0] speed_s2;

	logic      s2_free;
	logic      adv_s1;
	step_req_t req;
	step_rsp_t rsp;

	// Result register can take a beat when empty or being drained this edge.
	assign s2_free  = !valid_s2 || m_tready;
	assign adv_s1   = valid_s1 && s2_free;
	assign s_tready = !valid_s1 || s2_free;

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			cmd_s1  <= cmd_t'(s_tuser);
			data_s1 <= s_tdata;
		end
	end

	assign req.adv  = adv_s1;
	assign req.cmd  = cmd_s1;
	assign req.data = data_s1;

	jkie_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	// Result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			status_s2 <= rsp.status;
			speed_s2  <= rsp.speed;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = status_s2;
	assign m_tdata  = {6'd0, speed_s2};

endmodule

[hw/rtl/jkie_core.sv]
// Key matcher, value collector and parser state for one byte per cycle while req.adv is set.
module jkie_core import jkie_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  step_req_t req,
	output step_rsp_t rsp
);

	logic [POS_W-1:0]   match_q, match_d;
	phase_t             phase_q, phase_d;
	logic [SPEED_W-1:0] acc_q, acc_d;
	logic [CNT_W-1:0]   cnt_q, cnt_d;
	logic               dend_q, dend_d;

	logic [POS_W-1:0]   pos_eff;
	logic [POS_W:0]     pos_n;
	logic               is_digit;
	logic [3:0]         digit;
	logic [SPEED_W+3:0] prod;
	logic [SPEED_W-1:0] acc_sat;

	assign pos_eff  = (match_q >= POS_W'(KEY_LEN)) ? '0 : match_q;
	assign is_digit = (req.data >= DIGIT_ZERO) && (req.data <= DIGIT_NINE);
	assign digit    = 4'(req.data - DIGIT_ZERO);
	// acc * 10 + digit, as two shifted adds
	assign prod     = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + {10'd0, digit};
	assign acc_sat  = (prod > (SPEED_W + 4)'(SPEED_MAX)) ? SPEED_W'(SPEED_MAX)
	                                                     : prod[SPEED_W-1:0];

	always_comb begin
		match_d    = match_q;
		phase_d    = phase_q;
		acc_d      = acc_q;
		cnt_d      = cnt_q;
		dend_d     = dend_q;
		rsp.status = ST_SEARCHING;
		rsp.speed  = '0;
		pos_n      = '0;
		if (req.cmd == CMD_NEW_RESPONSE) begin
			match_d = '0;
			phase_d = PH_SEARCH;
			acc_d   = '0;
			cnt_d   = '0;
			dend_d  = 1'b0;
		end else begin
			case (phase_q)
				PH_FOUND: begin
					rsp.status = ST_ALREADY;
					rsp.speed  = acc_q;
				end
				PH_COLLECT: begin
					if (req.data == VALUE_END) begin
						rsp.status = ST_FOUND_NOW;
						rsp.speed  = acc_q;
						phase_d    = PH_FOUND;
					end else if (cnt_q >= CNT_W'(MAX_VALUE_CHARS)) begin
						rsp.status = ST_TOO_LONG;
						match_d    = '0;
						phase_d    = PH_SEARCH;
						acc_d      = '0;
						cnt_d      = '0;
						dend_d     = 1'b0;
					end else begin
						cnt_d = cnt_q + CNT_W'(1);
						if (!dend_q && is_digit) begin
							acc_d = acc_sat;
						end else begin
							dend_d = 1'b1;
						end
					end
				end
				default: begin
					// mismatch retries the byte as the first key character
					if (req.data == KEY_TEXT[pos_eff]) begin
						pos_n = {1'b0, pos_eff} + (POS_W + 1)'(1);
					end else if (req.data == KEY_TEXT[0]) begin
						pos_n = (POS_W + 1)'(1);
					end else begin
						pos_n = '0;
					end
					if (pos_n >= (POS_W + 1)'(KEY_LEN)) begin
						match_d = '0;
						phase_d = PH_COLLECT;
						acc_d   = '0;
						cnt_d   = '0;
						dend_d  = 1'b0;
					end else begin
						match_d = pos_n[POS_W-1:0];
						phase_d = PH_SEARCH;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= '0;
			phase_q <= PH_SEARCH;
			acc_q   <= '0;
			cnt_q   <= '0;
			dend_q  <= 1'b0;
		end else if (req.adv) begin
			match_q <= match_d;
			phase_q <= phase_d;
			acc_q   <= acc_d;
			cnt_q   <= cnt_d;
			dend_q  <= dend_d;
		end
	end

	a_new_clears: assert property (@(posedge clk) disable iff (!arst_n)
		req.adv && req.cmd == CMD_NEW_RESPONSE |=> match_q == '0 && phase_q == PH_SEARCH
		&& acc_q == '0 && cnt_q == '0)
		else $error("new response did not clear parser state");

	a_found_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		req.adv && rsp.status == ST_FOUND_NOW |=> phase_q == PH_FOUND)
		else $error("value found but phase not FOUND");

	a_acc_range: assert property (@(posedge clk) disable iff (!arst_n)
		acc_q <= SPEED_W'(SPEED_MAX))
		else $error("accumulator above saturation limit");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_VALUE_CHARS))
		else $error("value character count beyond limit");

	a_too_long_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		req.adv && rsp.status == ST_TOO_LONG |=> phase_q == PH_SEARCH && match_q == '0)
		else $error("too-long value did not restart key search");

endmodule

[bench/tb_top.sv]
// Self-checking bench for the JSON key integer extractor: directed and random byte streams.
module tb_top;
	import jkie_pkg::*;

	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam int unsigned RANDOM_BEATS   = 990;
	localparam int unsigned MAX_REPORTS    = 30;

	typedef struct {
		status_t            status;
		logic [SPEED_W-1:0] speed;
	} speed_result_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic [1:0]  m_tuser;

	json_key_integer_extractor_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// key text as the bench sees it, quotes included
	string speed_key = "\"currentSpeed\":";

	// predicted parser state
	int unsigned key_matched;
	phase_t      parse_phase;
	int unsigned speed_acc;
	int unsigned chars_taken;
	bit          digits_over;

	speed_result_t expected_speed_q[$];

	int unsigned mismatches;
	int unsigned beats_sent;
	int unsigned results_seen;
	int unsigned found_count;
	int unsigned too_long_count;
	int unsigned already_count;

	// sender pacing
	bit          bursty;
	int unsigned burst_left;

	// receiver pacing
	logic [15:0] ready_pattern = 16'hffff;
	int unsigned ready_ticks;

	int unsigned idle_cycles;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// one step of the extractor on an accepted beat; queues the result it must give
	function automatic void extract_speed_step(cmd_t cmd, logic [7:0] b);
		speed_result_t r;
		int unsigned   pos;
		int unsigned   v;
		r.status = ST_SEARCHING;
		r.speed  = '0;
		if (cmd == CMD_NEW_RESPONSE) begin
			key_matched = 0;
			parse_phase = PH_SEARCH;
			speed_acc   = 0;
			chars_taken = 0;
			digits_over = 1'b0;
		end else if (parse_phase == PH_FOUND) begin
			r.status = ST_ALREADY;
			r.speed  = speed_acc[SPEED_W-1:0];
		end else if (parse_phase == PH_COLLECT) begin
			if (b == VALUE_END) begin
				r.status    = ST_FOUND_NOW;
				r.speed     = speed_acc[SPEED_W-1:0];
				parse_phase = PH_FOUND;
			end else if (chars_taken >= MAX_VALUE_CHARS) begin
				// over-long value: drop it and hunt for the key again
				r.status    = ST_TOO_LONG;
				key_matched = 0;
				parse_phase = PH_SEARCH;
				speed_acc   = 0;
				chars_taken = 0;
				digits_over = 1'b0;
			end else begin
				chars_taken = chars_taken + 1;
				if (!digits_over && b >= DIGIT_ZERO && b <= DIGIT_NINE) begin
					v = speed_acc * 10 + (b - DIGIT_ZERO);
					speed_acc = (v > SPEED_MAX) ? SPEED_MAX : v;
				end else begin
					digits_over = 1'b1;
				end
			end
		end else begin
			// restart-on-mismatch: a breaking byte may itself open the key
			pos = key_matched;
			if (b == speed_key[pos])
				pos = pos + 1;
			else
				pos = (b == speed_key[0]) ? 1 : 0;
			if (pos >= speed_key.len()) begin
				key_matched = 0;
				parse_phase = PH_COLLECT;
				speed_acc   = 0;
				chars_taken = 0;
				digits_over = 1'b0;
			end else begin
				key_matched = pos;
			end
		end
		expected_speed_q.push_back(r);
	endfunction

	task automatic report_mismatch(string what, int unsigned want, int unsigned got);
		if (mismatches < MAX_REPORTS)
			$display("mismatch on result %0d: %s expected %0d got %0d",
				results_seen, what, want, got);
		mismatches = mismatches + 1;
	endtask

	// drive one beat at the falling edge, hold it until taken
	task automatic send_beat(cmd_t cmd, logic [7:0] b);
		int unsigned gap;
		@(negedge clk);
		if (bursty && burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		if (burst_left > 0)
			burst_left = burst_left - 1;
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= b;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		extract_speed_step(cmd, b);
		beats_sent = beats_sent + 1;
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++)
			send_beat(CMD_DATA, s[i]);
	endtask

	task automatic new_response(logic [7:0] b);
		send_beat(CMD_NEW_RESPONSE, b);
	endtask

	task automatic send_key_prefix(int unsigned n);
		for (int unsigned i = 0; i < n; i++)
			send_beat(CMD_DATA, speed_key[i]);
	endtask

	// arbitrary byte, now and then a new-response beat in the middle of a stream
	task automatic send_noise_byte();
		if ($urandom_range(0, 49) == 0)
			new_response(8'($urandom_range(0, 255)));
		else
			send_beat(CMD_DATA, 8'($urandom_range(0, 255)));
	endtask

	// receiver: rotating ready pattern, replaced on each refresh by a random one or by always ready
	always @(negedge clk) begin
		ready_ticks = ready_ticks + 1;
		if (ready_ticks % 64 == 0) begin
			if ($urandom_range(0, 3) == 0)
				ready_pattern = 16'hffff;
			else
				ready_pattern = 16'($urandom_range(1, 16'hffff));
		end
		ready_pattern = {ready_pattern[14:0], ready_pattern[15]};
		m_tready <= ready_pattern[0];
	end

	// result checker: every taken result against the oldest prediction
	always @(posedge clk) begin
		speed_result_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_speed_q.size() == 0) begin
				report_mismatch("unexpected result, status", 0, m_tuser);
			end else begin
				e = expected_speed_q.pop_front();
				if (m_tuser !== e.status)
					report_mismatch("status", e.status, m_tuser);
				if (m_tdata[SPEED_W-1:0] !== e.speed)
					report_mismatch("speed", e.speed, m_tdata[SPEED_W-1:0]);
				if (m_tdata[15:SPEED_W] !== '0)
					report_mismatch("tdata pad", 0, m_tdata[15:SPEED_W]);
				case (e.status)
					ST_FOUND_NOW: found_count = found_count + 1;
					ST_TOO_LONG:  too_long_count = too_long_count + 1;
					ST_ALREADY:   already_count = already_count + 1;
					default: ;
				endcase
			end
			results_seen = results_seen + 1;
		end
	end

	// watchdog: too long without any beat on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles = idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: %0d cycles with no beat, %0d results outstanding",
					idle_cycles, expected_speed_q.size());
				$display("tb_top NOT OK");
				$finish;
			end
		end
	end

	// digits and commas before any key must leave the matcher searching
	task automatic test_search_only();
		bursty = 1'b0;
		send_text("12,");
		send_beat(CMD_DATA, 8'hff);
		send_beat(CMD_DATA, 8'h00);
	endtask

	// comma straight after the key, then ignored bytes
	task automatic test_empty_value();
		new_response(8'hff);
		send_text(speed_key);
		send_text(",");
		send_beat(CMD_DATA, 8'h00);
		send_beat(CMD_DATA, 8'hff);
	endtask

	// a quote breaking a partial match restarts the key at its first character
	task automatic test_matcher_restart();
		new_response(8'h00);
		send_text("\"cur");
		send_text(speed_key);
		send_text("42,");
	endtask

	// fourth value character overflows; search resumes and finds the next key
	task automatic test_value_too_long();
		bursty = 1'b1;
		new_response(8'h5a);
		send_text(speed_key);
		send_text("1234");
		send_text("5,");
		send_text(speed_key);
		send_text("999,,");
	endtask

	// non-digits end the digit run but count toward the length
	task automatic test_non_digit_value();
		new_response(8'ha5);
		send_text(speed_key);
		send_text("7a5,");
		new_response(8'h01);
		send_text(speed_key);
		send_text("x9,");
	endtask

	// new-response beat in the middle of a value clears it
	task automatic test_new_mid_value();
		new_response(8'h80);
		send_text(speed_key);
		send_text("12");
		new_response(8'h7f);
		send_text(speed_key);
		send_text("3,");
	endtask

	// mostly well-formed responses with random content, plus noise and broken keys
	task automatic test_random_responses(int unsigned target);
		int unsigned start;
		int unsigned n;
		int unsigned shape;
		start = beats_sent;
		while (beats_sent - start < target) begin
			bursty = ($urandom_range(0, 3) != 0);
			new_response(8'($urandom_range(0, 255)));
			n = $urandom_range(0, 6);
			for (int unsigned i = 0; i < n; i++) begin
				if ($urandom_range(0, 2) == 0)
					send_key_prefix($urandom_range(1, speed_key.len() - 1));
				send_noise_byte();
			end
			shape = $urandom_range(0, 9);
			if (shape == 0) begin
				// no key at all
				repeat ($urandom_range(1, 8)) send_noise_byte();
			end else if (shape == 1) begin
				// key with one character spoilt
				n = $urandom_range(0, speed_key.len() - 1);
				for (int unsigned i = 0; i < speed_key.len(); i++)
					send_beat(CMD_DATA,
						(i == n) ? 8'($urandom_range(0, 255)) : 8'(speed_key[i]));
			end else begin
				send_text(speed_key);
			end
			// value: up to one character beyond the limit
			n = $urandom_range(0, MAX_VALUE_CHARS + 1);
			for (int unsigned i = 0; i < n; i++) begin
				if ($urandom_range(0, 4) == 0)
					send_beat(CMD_DATA, 8'($urandom_range(0, 255)));
				else
					send_beat(CMD_DATA, 8'(DIGIT_ZERO + $urandom_range(0, 9)));
			end
			if ($urandom_range(0, 9) != 0)
				send_beat(CMD_DATA, VALUE_END);
			repeat ($urandom_range(0, 4)) send_noise_byte();
		end
	endtask

	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = 1'b0;
		key_matched = 0;
		parse_phase = PH_SEARCH;
		speed_acc   = 0;
		chars_taken = 0;
		digits_over = 1'b0;
		mismatches  = 0;
		beats_sent  = 0;
		results_seen = 0;
		found_count  = 0;
		too_long_count = 0;
		already_count  = 0;
		bursty      = 1'b0;
		burst_left  = 0;
		ready_ticks = 0;
		idle_cycles = 0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		test_search_only();
		test_empty_value();
		test_matcher_restart();
		test_value_too_long();
		test_non_digit_value();
		test_new_mid_value();
		test_random_responses(RANDOM_BEATS);

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (expected_speed_q.size() != 0)
			@(posedge clk);
		// let the clock run on so any stray result would show up
		repeat (10) @(posedge clk);

		$display("%0d beats sent, %0d results checked", beats_sent, results_seen);
		$display("values found %0d, over-long values %0d, ignored after find %0d",
			found_count, too_long_count, already_count);
		if (mismatches == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule

[json_key_integer_extractor_top.f]
hw/rtl/jkie_pkg.sv
hw/rtl/jkie_core.sv
hw/rtl/json_key_integer_extractor_top.sv
bench/tb_top.sv
